// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the port scanner checkers
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, switched off while reset is held
`define SRPS_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds across reset
`define SRPS_ASSERT_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/srps_pkg.sv
// ----------------------------------------------------------------------------
// srps_pkg
// types and constants shared by the search reply port scanner
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package srps_pkg;

  // message header size in bytes
  localparam int HEADER_BYTES = 16;

  // configuration register index width and register map
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PAYLOAD_OFFSET = 1'b0,
    REG_MIN_PORT       = 1'b1
  } cfg_reg_t;

  // register reset values
  localparam logic [7:0]  OFFSET_RESET   = 8'd28;
  localparam logic [15:0] MIN_PORT_RESET = 16'd1024;

  // header match values
  localparam logic [15:0] MATCH_COMMAND = 16'h0006;
  localparam logic [31:0] MATCH_PARAM1  = 32'hFFFF_FFFF;

  // scan phases
  typedef enum logic [1:0] {
    PH_PREFIX = 2'd0,
    PH_HEADER = 2'd1,
    PH_SKIP   = 2'd2,
    PH_DONE   = 2'd3
  } phase_t;

  // result verdict codes
  typedef enum logic [1:0] {
    VERDICT_NONE   = 2'd0,
    VERDICT_ACCEPT = 2'd1,
    VERDICT_REFUSE = 2'd2
  } verdict_t;

  // one result beat
  typedef struct packed {
    verdict_t    verdict;
    logic [15:0] found_port;
  } result_t;

endpackage

// File: rtl/srps_if.sv
// ----------------------------------------------------------------------------
// srps_if
// valid/ready channels of the port scanner: packet bytes, results, config
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// packet byte channel
interface srps_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// result channel
interface srps_out_if;
  import srps_pkg::*;
  logic        valid;
  logic        ready;
  verdict_t    verdict;
  logic [15:0] found_port;

  modport source (output valid, output verdict, output found_port, input ready);
  modport sink   (input valid, input verdict, input found_port, output ready);
endinterface

// configuration write channel
interface srps_cfg_if;
  import srps_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/srps_scan.sv
// ----------------------------------------------------------------------------
// srps_scan
// per-byte scan state: prefix skip, header collect, payload skip, match
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module srps_scan #(
  parameter int HEADER_BYTES = srps_pkg::HEADER_BYTES
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              take,
  input  logic [7:0]        data_byte,
  input  logic              last_byte,
  input  logic [7:0]        payload_offset,
  input  logic [15:0]       min_port,
  output logic              push,
  output srps_pkg::result_t result
);
  import srps_pkg::*;

  localparam int          IDX_W    = $clog2(HEADER_BYTES);
  localparam logic [15:0] LAST_IDX = 16'(HEADER_BYTES - 1);

  phase_t      phase_r, phase_nxt;
  logic [15:0] count_r, count_nxt;
  verdict_t    held_v_r, held_v_nxt;
  logic [15:0] held_p_r, held_p_nxt;
  logic [7:0]  store_r [HEADER_BYTES];

  logic        hdr_take;
  logic [15:0] base;
  verdict_t    scan_v;
  logic [15:0] scan_p;

  // header fields, big-endian; the final header byte is never used
  logic [15:0] command;
  logic [15:0] size;
  logic [15:0] dtype;
  logic [31:0] param1;

  assign command = {store_r[0], store_r[1]};
  assign size    = {store_r[2], store_r[3]};
  assign dtype   = {store_r[4], store_r[5]};
  assign param1  = {store_r[8], store_r[9], store_r[10], store_r[11]};

  // next scan state for one byte
  always_comb begin
    phase_nxt = phase_r;
    count_nxt = count_r;
    scan_v    = held_v_r;
    scan_p    = held_p_r;
    hdr_take  = 1'b0;
    base      = count_r;
    if (take) begin
      unique case (phase_r)
        PH_PREFIX: begin
          if (count_r < {8'd0, payload_offset}) begin
            count_nxt = count_r + 16'd1;
          end else begin
            hdr_take = 1'b1;
            base     = '0;
          end
        end
        PH_SKIP: begin
          if (count_r != 16'd0) begin
            count_nxt = count_r - 16'd1;
          end else begin
            hdr_take = 1'b1;
            base     = '0;
          end
        end
        PH_HEADER: hdr_take = 1'b1;
        PH_DONE:   hdr_take = 1'b0;
      endcase
    end

    // header byte, judge on the final one
    if (hdr_take) begin
      if (base == LAST_IDX) begin
        if (command == MATCH_COMMAND && param1 == MATCH_PARAM1) begin
          scan_p    = dtype;
          scan_v    = (dtype < min_port) ? VERDICT_REFUSE : VERDICT_ACCEPT;
          phase_nxt = PH_DONE;
          count_nxt = '0;
        end else if (size == 16'd0) begin
          phase_nxt = PH_HEADER;
          count_nxt = '0;
        end else begin
          phase_nxt = PH_SKIP;
          count_nxt = size;
        end
      end else begin
        phase_nxt = PH_HEADER;
        count_nxt = base + 16'd1;
      end
    end

    held_v_nxt = scan_v;
    held_p_nxt = scan_p;

    // final byte rearms the scan
    if (take && last_byte) begin
      phase_nxt  = PH_PREFIX;
      count_nxt  = '0;
      held_v_nxt = VERDICT_NONE;
      held_p_nxt = '0;
    end
  end

  assign push              = take & last_byte;
  assign result.verdict    = scan_v;
  assign result.found_port = (scan_v != VERDICT_NONE) ? scan_p : 16'd0;

  // scan state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_PREFIX;
      count_r  <= '0;
      held_v_r <= VERDICT_NONE;
      held_p_r <= '0;
    end else begin
      phase_r  <= phase_nxt;
      count_r  <= count_nxt;
      held_v_r <= held_v_nxt;
      held_p_r <= held_p_nxt;
    end
  end

  // header byte store
  always_ff @(posedge clk) begin
    if (hdr_take) begin
      store_r[base[IDX_W-1:0]] <= data_byte;
    end
  end

endmodule

// File: rtl/srps_outq.sv
// ----------------------------------------------------------------------------
// srps_outq
// two-slot result queue: output register plus skid slot
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module srps_outq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  srps_pkg::result_t push_data,
  output logic              has_room,
  output logic              out_valid,
  input  logic              out_ready,
  output srps_pkg::result_t out_data
);
  import srps_pkg::*;

  logic    out_valid_r, out_valid_nxt;
  logic    skid_valid_r, skid_valid_nxt;
  result_t out_r, out_nxt;
  result_t skid_r, skid_nxt;
  logic    pop;

  assign pop       = out_valid_r & out_ready;
  assign has_room  = ~skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // slot movement
  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_nxt        = out_r;
    skid_nxt       = skid_r;
    if (!out_valid_r || pop) begin
      if (skid_valid_r) begin
        out_nxt        = skid_r;
        out_valid_nxt  = 1'b1;
        skid_nxt       = push_data;
        skid_valid_nxt = push;
      end else begin
        out_nxt       = push_data;
        out_valid_nxt = push;
      end
    end else if (push) begin
      skid_nxt       = push_data;
      skid_valid_nxt = 1'b1;
    end
  end

  // valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  // payload slots
  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

endmodule

// File: rtl/search_reply_port_scanner.sv
// ----------------------------------------------------------------------------
// search_reply_port_scanner
// scans a packet for a search reply header and reports the announced port
// ----------------------------------------------------------------------------
// Takes packet bytes, counted from the IP header, and gives one registered
// result beat for each beat flagged as the last byte of a packet. Each byte
// costs one counter step and one compare in the scan registers, so a new byte
// is taken every cycle while the output queue has room. Results pass through a
// two-slot output queue; the byte channel stalls only while both slots hold
// results that the sink has not taken. Configuration writes are taken every
// cycle and apply from the next byte. No clearing pass follows reset.
`timescale 1ns / 1ps

module search_reply_port_scanner #(
  parameter int HEADER_BYTES = srps_pkg::HEADER_BYTES
) (
  input logic              clk,
  input logic              rst_n,
  srps_in_if.sink          in_ch,
  srps_out_if.source       out_ch,
  srps_cfg_if.sink         cfg_ch
);
  import srps_pkg::*;

  logic [7:0]  offset_r, offset_nxt;
  logic [15:0] min_port_r, min_port_nxt;
  logic        take;
  logic        push;
  logic        has_room;
  result_t     scan_res;
  result_t     out_res;

  // configuration registers
  assign cfg_ch.ready = 1'b1;

  always_comb begin
    offset_nxt   = offset_r;
    min_port_nxt = min_port_r;
    if (cfg_ch.valid) begin
      unique case (cfg_reg_t'(cfg_ch.index))
        REG_PAYLOAD_OFFSET: offset_nxt   = cfg_ch.data[7:0];
        REG_MIN_PORT:       min_port_nxt = cfg_ch.data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r   <= OFFSET_RESET;
      min_port_r <= MIN_PORT_RESET;
    end else begin
      offset_r   <= offset_nxt;
      min_port_r <= min_port_nxt;
    end
  end

  // byte beat handshake
  assign in_ch.ready = has_room;
  assign take        = in_ch.valid & has_room;

  srps_scan #(
    .HEADER_BYTES (HEADER_BYTES)
  ) u_scan (
    .clk            (clk),
    .rst_n          (rst_n),
    .take           (take),
    .data_byte      (in_ch.data_byte),
    .last_byte      (in_ch.last_byte),
    .payload_offset (offset_r),
    .min_port       (min_port_r),
    .push           (push),
    .result         (scan_res)
  );

  srps_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (scan_res),
    .has_room  (has_room),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_res)
  );

  // result beat payload
  assign out_ch.verdict    = out_res.verdict;
  assign out_ch.found_port = out_res.found_port;

endmodule

// File: rtl/srps_check.sv
// ----------------------------------------------------------------------------
// srps_check
// port-level checks on the port scanner, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module srps_check (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_last_byte,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_verdict,
  input logic [15:0] out_found_port
);
  import srps_pkg::*;

  // no result is pending right after reset
  `SRPS_ASSERT_NR(a_idle_after_reset, clk, !rst_n |=> !out_valid, "result valid after reset")

  // a new result only follows a last-byte beat
  `SRPS_ASSERT(a_result_has_cause, clk, rst_n, $rose(out_valid) |-> $past(in_valid && in_ready && in_last_byte), "result without last byte")

  // no port is reported without a search reply
  `SRPS_ASSERT(a_port_zero_on_none, clk, rst_n, (out_valid && out_verdict == VERDICT_NONE) |-> out_found_port == 16'd0, "port on empty verdict")

  // a stalled result stays offered
  `SRPS_ASSERT(a_out_hold, clk, rst_n, (out_valid && !out_ready) |=> out_valid, "result dropped while stalled")

endmodule

bind search_reply_port_scanner srps_check u_srps_check (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .in_last_byte   (in_ch.last_byte),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_verdict    (out_ch.verdict),
  .out_found_port (out_ch.found_port)
);
